[hw/rtl/sec_pkg.sv]
// Package for the step event coalescer: field types, limits, codes and reset values.
package sec_pkg;

  localparam int unsigned MagW   = 20;
  localparam int unsigned SumW   = 24;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgW   = 32;

  typedef logic [MagW-1:0]   mag_t;
  typedef logic [SumW-1:0]   sum_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CfgW-1:0]   cfg_data_t;

  typedef enum logic {
    ActEvent = 1'b0,
    ActTick  = 1'b1
  } action_e;

  typedef enum logic {
    CfgMergeWindow    = 1'b0,
    CfgSampleInterval = 1'b1
  } cfg_index_e;

  localparam sum_t   SumMax   = {SumW{1'b1}};
  localparam count_t CountMax = {CountW{1'b1}};

  localparam time_t MergeWindowReset    = 32'd100000;
  localparam time_t SampleIntervalReset = 32'd20000;

endpackage

[hw/rtl/step_event_coalescer.sv]
// Step event coalescer: merges fragments of one power step into a single released event.
//
// Input channel: in_valid_i / in_stall_o carry one request per item: an event fragment
// (action 0) with direction, magnitude and timestamp, or a time tick (action 1) that
// only uses now_us_i. A request is taken at an edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry exactly one result per request.
// released_o says whether a merged event comes out; when it is low the event fields
// are zero.
// Pipeline: an accepted request passes the input register, then the merge/release
// decision is written into the result register.
// Throughput: one request per cycle while the output is not stalled; the pending-event
// state is read and rewritten between the two registers, so back-to-back requests see
// each other's updates.
// Stall: while out_stall_i holds a result, the input register keeps its request and
// in_stall_o rises once it is full; nothing is dropped or repeated.
// Reset: no pending event, all time marks zero, merge window 100000 us, sample interval 20000 us.
// The user must make configuration writes only while no request is in flight; the block does not enforce this.
module step_event_coalescer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic               direction_i,
  input  sec_pkg::mag_t      magnitude_va_i,
  input  sec_pkg::time_t     dated_us_i,
  input  sec_pkg::time_t     now_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               released_o,
  output logic               out_direction_o,
  output sec_pkg::sum_t      out_magnitude_va_o,
  output sec_pkg::time_t     out_dated_us_o,
  output sec_pkg::count_t    out_fragments_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  sec_pkg::cfg_data_t cfg_wdata_i
);
  import sec_pkg::*;

  // configuration
  time_t win_q, sint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= MergeWindowReset;
      sint_q <= SampleIntervalReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgMergeWindow:    win_q  <= cfg_wdata_i;
        CfgSampleInterval: sint_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic    s1_valid_q;
  action_e s1_action_q;
  logic    s1_dir_q;
  mag_t    s1_mag_q;
  time_t   s1_dated_q, s1_now_q;
  logic    s1_adv, in_take;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= action_e'(action_i);
      s1_dir_q    <= direction_i;
      s1_mag_q    <= magnitude_va_i;
      s1_dated_q  <= dated_us_i;
      s1_now_q    <= now_us_i;
    end
  end

  // pending event state
  logic   pend_valid_q, pend_valid_d;
  logic   pend_dir_q, pend_dir_d;
  sum_t   pend_sum_q, pend_sum_d;
  time_t  pend_first_q, pend_first_d;
  count_t pend_count_q, pend_count_d;
  time_t  last_dated_q, last_dated_d;
  time_t  last_arr_q, last_arr_d;

  logic            fire, is_tick, in_win, past_win, join_ev, rel;
  time_t           dated_diff, arr_diff;
  logic [TimeW:0]  limit;
  logic [SumW:0]   sum_raw;

  assign fire       = s1_valid_q && s1_adv;
  assign is_tick    = (s1_action_q == ActTick);
  assign dated_diff = s1_dated_q - last_dated_q;
  assign arr_diff   = s1_now_q - last_arr_q;
  // window plus half the sample interval, kept at 33 bits so it cannot wrap
  assign limit      = {1'b0, win_q} + {2'b00, sint_q[TimeW-1:1]};
  assign in_win     = {1'b0, dated_diff} <= limit;
  assign past_win   = arr_diff > win_q;
  assign join_ev    = !is_tick && pend_valid_q && (s1_dir_q == pend_dir_q) && in_win;
  assign rel        = pend_valid_q && (is_tick ? past_win : !join_ev);
  assign sum_raw    = {1'b0, pend_sum_q} + {{(SumW-MagW+1){1'b0}}, s1_mag_q};

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_dir_d   = pend_dir_q;
    pend_sum_d   = pend_sum_q;
    pend_first_d = pend_first_q;
    pend_count_d = pend_count_q;
    last_dated_d = last_dated_q;
    last_arr_d   = last_arr_q;
    if (fire) begin
      if (is_tick) begin
        if (rel) begin
          pend_valid_d = 1'b0;
        end
      end else if (join_ev) begin
        pend_sum_d   = sum_raw[SumW] ? SumMax : sum_raw[SumW-1:0];
        if (pend_count_q != CountMax) begin
          pend_count_d = pend_count_q + count_t'(1);
        end
        last_dated_d = s1_dated_q;
        last_arr_d   = s1_now_q;
      end else begin
        pend_valid_d = 1'b1;
        pend_dir_d   = s1_dir_q;
        pend_sum_d   = {{(SumW-MagW){1'b0}}, s1_mag_q};
        pend_first_d = s1_dated_q;
        pend_count_d = count_t'(1);
        last_dated_d = s1_dated_q;
        last_arr_d   = s1_now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_dir_q   <= 1'b0;
      pend_sum_q   <= '0;
      pend_first_q <= '0;
      pend_count_q <= '0;
      last_dated_q <= '0;
      last_arr_q   <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_dir_q   <= pend_dir_d;
      pend_sum_q   <= pend_sum_d;
      pend_first_q <= pend_first_d;
      pend_count_q <= pend_count_d;
      last_dated_q <= last_dated_d;
      last_arr_q   <= last_arr_d;
    end
  end

  // result register
  logic   out_valid_q;
  logic   rel_q, odir_q;
  sum_t   omag_q;
  time_t  odated_q;
  count_t ofrag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rel_q    <= rel;
      odir_q   <= rel ? pend_dir_q : 1'b0;
      omag_q   <= rel ? pend_sum_q : '0;
      odated_q <= rel ? pend_first_q : '0;
      ofrag_q  <= rel ? pend_count_q : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign released_o         = rel_q;
  assign out_direction_o    = odir_q;
  assign out_magnitude_va_o = omag_q;
  assign out_dated_us_o     = odated_q;
  assign out_fragments_o    = ofrag_q;

  // checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q) else $error("input stalled with empty input register");

  a_pending_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_count_q != '0)) else $error("pending event with zero count");

  a_event_leaves_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !is_tick) |=> pend_valid_q) else $error("event request left nothing pending");

  a_release_has_frags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && released_o) |-> (out_fragments_o != '0))
    else $error("released event with no fragments");

  a_quiet_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !released_o) |-> (out_fragments_o == '0 && out_magnitude_va_o == '0))
    else $error("non-release result carries event data");

endmodule

[sim/step_event_coalescer_tb.sv]
// Self-checking testbench for the step event coalescer: directed, backpressure and random runs.
module step_event_coalescer_tb;
  import sec_pkg::*;

  typedef struct packed {
    action_e action;
    logic    dir;
    mag_t    mag;
    time_t   dated;
    time_t   now;
  } step_req_t;

  typedef struct packed {
    logic   released;
    logic   dir;
    sum_t   magnitude;
    time_t  dated;
    count_t fragments;
  } merged_event_t;

  localparam mag_t MagMax = '1;

  logic      clk = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  logic      action;
  logic      direction;
  mag_t      magnitude;
  time_t     dated;
  time_t     now;
  logic      out_valid;
  logic      out_stall;
  logic      released;
  logic      out_direction;
  sum_t      out_magnitude;
  time_t     out_dated;
  count_t    out_fragments;
  logic      cfg_we;
  logic      cfg_index;
  cfg_data_t cfg_wdata;

  // predictor copy of the registers and the open event
  time_t  window_us;
  time_t  interval_us;
  logic   open_valid;
  logic   open_dir;
  sum_t   open_sum;
  time_t  open_start;
  count_t open_frags;
  time_t  prev_dated;
  time_t  prev_arrival;

  merged_event_t expected_events[$];
  int mismatches = 0;
  int results_seen = 0;
  int send_gap_max = 16;
  int recv_stall_max = 16;
  logic hold_on = 1'b0;

  // random traffic cursors
  time_t cursor_dated = '0;
  time_t cursor_now = '0;
  logic  cursor_dir = 1'b0;

  step_event_coalescer dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .action_i           (action),
    .direction_i        (direction),
    .magnitude_va_i     (magnitude),
    .dated_us_i         (dated),
    .now_us_i           (now),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .released_o         (released),
    .out_direction_o    (out_direction),
    .out_magnitude_va_o (out_magnitude),
    .out_dated_us_o     (out_dated),
    .out_fragments_o    (out_fragments),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic merged_event_t release_open();
    merged_event_t res;
    res = '0;
    if (open_valid) begin
      res.released  = 1'b1;
      res.dir       = open_dir;
      res.magnitude = open_sum;
      res.dated     = open_start;
      res.fragments = open_frags;
      open_valid    = 1'b0;
    end
    return res;
  endfunction

  function automatic merged_event_t coalesce(step_req_t r);
    merged_event_t res;
    logic [32:0]   reach;
    logic [24:0]   total;
    time_t         gap_us;
    time_t         idle_us;
    res = '0;
    if (r.action == ActTick) begin
      idle_us = r.now - prev_arrival;
      if (open_valid && idle_us > window_us) res = release_open();
      return res;
    end
    // window plus tolerance at full precision, so a huge sum takes every difference
    reach  = {1'b0, window_us} + {2'b00, interval_us[31:1]};
    gap_us = r.dated - prev_dated;
    if (open_valid && r.dir == open_dir && {1'b0, gap_us} <= reach) begin
      total    = {1'b0, open_sum} + {5'b0, r.mag};
      open_sum = (total > SumMax) ? SumMax : total[SumW-1:0];
      if (open_frags != CountMax) open_frags = open_frags + 1'b1;
      prev_dated   = r.dated;
      prev_arrival = r.now;
      return res;
    end
    res          = release_open();
    open_valid   = 1'b1;
    open_dir     = r.dir;
    open_sum     = {4'b0, r.mag};
    open_start   = r.dated;
    open_frags   = 16'd1;
    prev_dated   = r.dated;
    prev_arrival = r.now;
    return res;
  endfunction

  function automatic step_req_t fragment_req(logic d, mag_t m, time_t dt, time_t nw);
    step_req_t r;
    r.action = ActEvent;
    r.dir    = d;
    r.mag    = m;
    r.dated  = dt;
    r.now    = nw;
    return r;
  endfunction

  // ticks carry random junk in the fields they ignore
  function automatic step_req_t tick_req(time_t nw);
    step_req_t r;
    r.action = ActTick;
    r.dir    = 1'($urandom_range(0, 1));
    r.mag    = mag_t'($urandom());
    r.dated  = $urandom();
    r.now    = nw;
    return r;
  endfunction

  // offsets on, just past and inside a time span, plus far jumps
  function automatic time_t span_offset(time_t span);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return span;
      2: return span + 1'b1;
      3: return (span == '0) ? '0 : time_t'($urandom_range(0, span));
      4: return time_t'($urandom_range(0, 3));
      default: return time_t'($urandom());
    endcase
  endfunction

  function automatic step_req_t random_request();
    step_req_t   r;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    r       = tick_req($urandom());
    r.action = ActEvent;
    if (pick < 8) begin
      if ($urandom_range(0, 1)) r.action = ActTick;
    end else if (pick < 30) begin
      r.action   = ActTick;
      cursor_now = cursor_now + span_offset(window_us);
      r.now      = cursor_now;
    end else begin
      if ($urandom_range(0, 4) == 0) cursor_dir = ~cursor_dir;
      r.dir = cursor_dir;
      case ($urandom_range(0, 3))
        0: r.mag = '0;
        1: r.mag = MagMax;
        default: ;
      endcase
      cursor_dated = cursor_dated + span_offset(window_us + (interval_us >> 1));
      if ($urandom_range(0, 2) == 0) cursor_now = cursor_now + span_offset(window_us);
      else cursor_now = cursor_now + time_t'($urandom_range(0, 64));
      r.dated = cursor_dated;
      r.now   = cursor_now;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  task automatic check_result();
    merged_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("no request outstanding", 32'd1, 32'd0);
      return;
    end
    want = expected_events.pop_front();
    results_seen++;
    if (released !== want.released)
      report_mismatch("released", 32'(released), 32'(want.released));
    if (out_direction !== want.dir)
      report_mismatch("direction", 32'(out_direction), 32'(want.dir));
    if (out_magnitude !== want.magnitude)
      report_mismatch("magnitude", 32'(out_magnitude), 32'(want.magnitude));
    if (out_dated !== want.dated) report_mismatch("dated", out_dated, want.dated);
    if (out_fragments !== want.fragments)
      report_mismatch("fragments", 32'(out_fragments), 32'(want.fragments));
  endtask

  task automatic send_request(step_req_t r);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action    = r.action;
    direction = r.dir;
    magnitude = r.mag;
    dated     = r.dated;
    now       = r.now;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_events.push_back(coalesce(r));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_e idx, cfg_data_t val);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgMergeWindow) window_us = val;
    else interval_us = val;
  endtask

  task automatic set_config(cfg_data_t window, cfg_data_t interval);
    write_register(CfgMergeWindow, window);
    write_register(CfgSampleInterval, interval);
  endtask

  task automatic hold_output(int cycles);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on = 1'b0;
  endtask

  // reset settings: window 100000, tolerance 10000
  task automatic test_reset_behavior();
    time_t t0;
    t0 = 32'hFFFF_FFF0;
    send_request(tick_req(32'hFFFF_FFFF));
    send_request(fragment_req(1'b1, MagMax, t0, 32'd0));
    // exactly window plus tolerance, across the wrap
    send_request(fragment_req(1'b1, MagMax, t0 + 32'd110000, 32'd5));
    repeat (15) send_request(fragment_req(1'b1, MagMax, t0 + 32'd110000, 32'd10));
    send_request(fragment_req(1'b1, '0, t0 + 32'd220001, 32'd20));
    send_request(fragment_req(1'b0, 20'd7, t0 + 32'd220001, 32'd30));
    send_request(tick_req(32'd100030));
    send_request(tick_req(32'd100031));
    send_request(tick_req(32'hFFFF_FFFF));
    send_request(fragment_req(1'b0, 20'd1, 32'd0, 32'hFFFF_FF00));
    // one microsecond back is a near-full wrap forward
    send_request(fragment_req(1'b0, 20'd2, 32'hFFFF_FFFF, 32'hFFFF_FF10));
    send_request(tick_req(32'd100));
    drain_results();
  endtask

  task automatic test_register_extremes();
    set_config(32'd0, 32'd1);
    send_request(fragment_req(1'b0, 20'd3, 32'd500, 32'd500));
    send_request(fragment_req(1'b0, 20'd4, 32'd500, 32'd500));
    send_request(fragment_req(1'b0, 20'd5, 32'd501, 32'd500));
    send_request(tick_req(32'd500));
    send_request(tick_req(32'd501));
    set_config(32'd0, 32'd0);
    send_request(fragment_req(1'b1, 20'd9, 32'd10, 32'd10));
    send_request(fragment_req(1'b1, 20'd9, 32'd10, 32'd11));
    send_request(tick_req(32'd11));
    send_request(fragment_req(1'b1, 20'd9, 32'd11, 32'd12));
    set_config(32'd1000, 32'd3);
    send_request(fragment_req(1'b1, 20'd1, 32'd0, 32'd0));
    send_request(fragment_req(1'b1, 20'd1, 32'd1001, 32'd1));
    send_request(fragment_req(1'b1, 20'd1, 32'd2003, 32'd2));
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(fragment_req(1'b1, MagMax, 32'd0, 32'd0));
    send_request(fragment_req(1'b1, MagMax, 32'h8000_0000, 32'd7));
    send_request(fragment_req(1'b1, MagMax, 32'h7FFF_FFFF, 32'd9));
    send_request(tick_req(32'd8));
    send_request(fragment_req(1'b0, '0, 32'd1, 32'd10));
    drain_results();
  endtask

  task automatic test_output_backpressure();
    set_config(MergeWindowReset, SampleIntervalReset);
    send_gap_max = 0;
    fork
      hold_output(300);
    join_none
    repeat (60) send_request(random_request());
    drain_results();
    send_gap_max   = 16;
    recv_stall_max = 16;
    repeat (60) send_request(random_request());
    drain_results();
  endtask

  task automatic test_long_merge();
    set_config(MergeWindowReset, SampleIntervalReset);
    send_gap_max   = 0;
    recv_stall_max = 0;
    repeat (40) send_request(fragment_req(1'b1, 20'd1, 32'd1234, 32'd1234));
    send_request(fragment_req(1'b0, 20'd3, 32'd1234, 32'd1234));
    send_request(tick_req(32'd900000));
    drain_results();
    send_gap_max   = 16;
    recv_stall_max = 16;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_config(MergeWindowReset, SampleIntervalReset);
        1: set_config(32'd0, 32'd1);
        2: set_config(32'd0, 32'd0);
        3: set_config($urandom_range(0, 5000), $urandom_range(1, 5000));
        4: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        5: set_config($urandom(), $urandom());
        default: set_config(32'd50, 32'hFFFF_FFFF);
      endcase
      for (int n = 0; n < 150; n++) begin
        if (n % 45 == 0) begin
          send_gap_max   = $urandom_range(0, 1) ? 16 : 0;
          recv_stall_max = $urandom_range(0, 1) ? 16 : 0;
        end
        send_request(random_request());
      end
    end
    send_gap_max   = 16;
    recv_stall_max = 16;
  endtask

  initial begin : result_monitor
    int wait_left;
    wait_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_ni && out_valid && !out_stall) begin
        check_result();
        wait_left = $urandom_range(0, recv_stall_max);
      end
      @(negedge clk);
      if (wait_left > 0) begin
        out_stall = 1'b1;
        wait_left--;
      end else begin
        out_stall = hold_on;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("step_event_coalescer regression: fail");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    action       = 1'b0;
    direction    = 1'b0;
    magnitude    = '0;
    dated        = '0;
    now          = '0;
    cfg_we       = 1'b0;
    cfg_index    = 1'b0;
    cfg_wdata    = '0;
    window_us    = MergeWindowReset;
    interval_us  = SampleIntervalReset;
    open_valid   = 1'b0;
    open_dir     = 1'b0;
    open_sum     = '0;
    open_start   = '0;
    open_frags   = '0;
    prev_dated   = '0;
    prev_arrival = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_reset_behavior();
    test_register_extremes();
    test_output_backpressure();
    test_long_merge();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("step_event_coalescer regression: pass");
    else $display("step_event_coalescer regression: fail");
    $finish;
  end

endmodule
